// ===== rtl/ucs_pkg.sv =====
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared types, constants and character helpers of the URI component
// splitter.
// ----------------------------------------------------------------------------
package ucs_pkg;

   localparam int MAX_SCHEME_LEN = 16;
   localparam int HOLD_CAP = (MAX_SCHEME_LEN > 18) ? 18 :
                             ((MAX_SCHEME_LEN < 1) ? 1 : MAX_SCHEME_LEN);
   localparam int HOLD_IDX_W = (HOLD_CAP > 1) ? $clog2(HOLD_CAP) : 1;
   localparam int HOLD_CNT_W = $clog2(HOLD_CAP + 1);

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CW = $clog2(CMDQ_DEPTH + 1);

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [2:0] COMP_SCHEME = 3'd0;
   localparam logic [2:0] COMP_AUTH   = 3'd1;
   localparam logic [2:0] COMP_PATH   = 3'd2;
   localparam logic [2:0] COMP_QUERY  = 3'd3;
   localparam logic [2:0] COMP_FRAG   = 3'd4;

   typedef struct packed {
      logic       en;
      logic [1:0] kind;
      logic [2:0] comp;
      logic [7:0] chr;
   } tail_type;

   typedef struct packed {
      logic                  start_en;
      logic [2:0]            start_comp;
      logic [HOLD_CNT_W-1:0] flush_cnt;
      logic                  slash_en;
      tail_type              tail;
   } cmd_type;

   typedef struct packed {
      logic                  en;
      logic [HOLD_IDX_W-1:0] addr;
      logic [7:0]            data;
   } hold_wr_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_scheme_tail(input logic [7:0] c);
      return is_letter(c) || (c >= 8'h30 && c <= 8'h39) ||
             c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
   endfunction

   function automatic tail_type path_byte(input logic [7:0] c);
      tail_type t;
      t.en = 1'b1;
      if (c == CH_QUEST) begin
         t.kind = KIND_START;
         t.comp = COMP_QUERY;
         t.chr  = 8'h00;
      end else if (c == CH_HASH) begin
         t.kind = KIND_START;
         t.comp = COMP_FRAG;
         t.chr  = 8'h00;
      end else begin
         t.kind = KIND_DATA;
         t.comp = COMP_PATH;
         t.chr  = c;
      end
      return t;
   endfunction

endpackage

// ===== rtl/ucs_front.sv =====
// ----------------------------------------------------------------------------
// ucs_front
// Accepts URI bytes, tracks the parse mode and the held scheme candidate,
// and turns each byte into at most one output command.
// ----------------------------------------------------------------------------
module ucs_front import ucs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_end,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd,
   output hold_wr_type hold_wr,
   input  logic        flush_done
);

   typedef enum logic [7:0] {
      MD_START  = 8'b0000_0001,
      MD_SCHEME = 8'b0000_0010,
      MD_BEGIN  = 8'b0000_0100,
      MD_SLASH  = 8'b0000_1000,
      MD_AUTH   = 8'b0001_0000,
      MD_PATH   = 8'b0010_0000,
      MD_QUERY  = 8'b0100_0000,
      MD_FRAG   = 8'b1000_0000
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [HOLD_CNT_W-1:0] hold_cnt_ff, hold_cnt_in;
   logic                  busy_ff, busy_in;
   logic                  accept;
   logic [7:0]            c;
   cmd_type               cmd;
   tail_type              pb;

   assign req_ready = !busy_ff && !q_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_char_code;
   assign pb        = path_byte(c);

   function automatic mode_type mode_of(input tail_type t);
      if (t.kind == KIND_START && t.comp == COMP_QUERY) begin
         return MD_QUERY;
      end else if (t.kind == KIND_START && t.comp == COMP_FRAG) begin
         return MD_FRAG;
      end else begin
         return MD_PATH;
      end
   endfunction

   always_comb begin
      cmd          = '0;
      mode_in      = mode_ff;
      hold_cnt_in  = hold_cnt_ff;
      hold_wr.en   = 1'b0;
      hold_wr.addr = hold_cnt_ff[HOLD_IDX_W-1:0];
      hold_wr.data = c;
      if (req_is_end) begin
         if (mode_ff == MD_SCHEME) begin
            cmd.start_en   = 1'b1;
            cmd.start_comp = COMP_PATH;
            cmd.flush_cnt  = hold_cnt_ff;
         end else if (mode_ff == MD_SLASH) begin
            cmd.start_en   = 1'b1;
            cmd.start_comp = COMP_PATH;
            cmd.slash_en   = 1'b1;
         end
         cmd.tail.en   = 1'b1;
         cmd.tail.kind = KIND_DONE;
         cmd.tail.comp = COMP_SCHEME;
         cmd.tail.chr  = 8'h00;
         mode_in       = MD_START;
         hold_cnt_in   = '0;
      end else begin
         unique case (mode_ff)
            MD_START, MD_BEGIN: begin
               if (mode_ff == MD_START && is_letter(c)) begin
                  hold_wr.en   = 1'b1;
                  hold_wr.addr = '0;
                  hold_cnt_in  = HOLD_CNT_W'(1);
                  mode_in      = MD_SCHEME;
               end else if (c == CH_SLASH) begin
                  mode_in = MD_SLASH;
               end else if (c == CH_QUEST || c == CH_HASH) begin
                  cmd.tail = pb;
                  mode_in  = mode_of(pb);
               end else begin
                  cmd.start_en   = 1'b1;
                  cmd.start_comp = COMP_PATH;
                  cmd.tail       = pb;
                  mode_in        = MD_PATH;
               end
            end
            MD_SCHEME: begin
               if (c == CH_COLON) begin
                  cmd.start_en   = 1'b1;
                  cmd.start_comp = COMP_SCHEME;
                  cmd.flush_cnt  = hold_cnt_ff;
                  hold_cnt_in    = '0;
                  mode_in        = MD_BEGIN;
               end else if (is_scheme_tail(c) && hold_cnt_ff < HOLD_CNT_W'(HOLD_CAP)) begin
                  hold_wr.en  = 1'b1;
                  hold_cnt_in = hold_cnt_ff + HOLD_CNT_W'(1);
               end else begin
                  cmd.start_en   = 1'b1;
                  cmd.start_comp = COMP_PATH;
                  cmd.flush_cnt  = hold_cnt_ff;
                  hold_cnt_in    = '0;
                  if (is_scheme_tail(c)) begin
                     cmd.tail.en   = 1'b1;
                     cmd.tail.kind = KIND_DATA;
                     cmd.tail.comp = COMP_PATH;
                     cmd.tail.chr  = c;
                     mode_in       = MD_PATH;
                  end else begin
                     cmd.tail = pb;
                     mode_in  = mode_of(pb);
                  end
               end
            end
            MD_SLASH: begin
               cmd.start_en = 1'b1;
               if (c == CH_SLASH) begin
                  cmd.start_comp = COMP_AUTH;
                  mode_in        = MD_AUTH;
               end else begin
                  cmd.start_comp = COMP_PATH;
                  cmd.slash_en   = 1'b1;
                  cmd.tail       = pb;
                  mode_in        = mode_of(pb);
               end
            end
            MD_AUTH: begin
               if (c == CH_SLASH) begin
                  cmd.start_en   = 1'b1;
                  cmd.start_comp = COMP_PATH;
                  cmd.slash_en   = 1'b1;
                  mode_in        = MD_PATH;
               end else if (c == CH_QUEST || c == CH_HASH) begin
                  cmd.tail = pb;
                  mode_in  = mode_of(pb);
               end else begin
                  cmd.tail.en   = 1'b1;
                  cmd.tail.kind = KIND_DATA;
                  cmd.tail.comp = COMP_AUTH;
                  cmd.tail.chr  = c;
               end
            end
            MD_PATH: begin
               cmd.tail = pb;
               mode_in  = mode_of(pb);
            end
            MD_QUERY: begin
               cmd.tail.en = 1'b1;
               if (c == CH_HASH) begin
                  cmd.tail.kind = KIND_START;
                  cmd.tail.comp = COMP_FRAG;
                  cmd.tail.chr  = 8'h00;
                  mode_in       = MD_FRAG;
               end else begin
                  cmd.tail.kind = KIND_DATA;
                  cmd.tail.comp = COMP_QUERY;
                  cmd.tail.chr  = c;
               end
            end
            MD_FRAG: begin
               cmd.tail.en   = 1'b1;
               cmd.tail.kind = KIND_DATA;
               cmd.tail.comp = COMP_FRAG;
               cmd.tail.chr  = c;
            end
            default: begin
               mode_in = MD_START;
            end
         endcase
      end
      if (!accept) begin
         hold_wr.en = 1'b0;
      end
   end

   assign q_cmd  = cmd;
   assign q_push = accept && (cmd.start_en || cmd.slash_en || cmd.tail.en);

   always_comb begin
      busy_in = busy_ff;
      if (q_push && cmd.flush_cnt != '0) begin
         busy_in = 1'b1;
      end else if (flush_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MD_START;
         hold_cnt_ff <= '0;
         busy_ff     <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff     <= mode_in;
            hold_cnt_ff <= hold_cnt_in;
         end
         busy_ff <= busy_in;
      end
   end

   a_hold_only_in_scheme: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MD_SCHEME) == (hold_cnt_ff != '0))
      else $error("hold count and scheme mode disagree");

   a_hold_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      hold_cnt_ff <= HOLD_CNT_W'(HOLD_CAP))
      else $error("hold count beyond buffer size");

endmodule

// ===== rtl/ucs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ucs_cmd_fifo
// Short command queue between the parse front and the output back end.
// ----------------------------------------------------------------------------
module ucs_cmd_fifo import ucs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type            mem_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0] cnt_ff, cnt_in;

   assign full       = cnt_ff == CMDQ_CW'(CMDQ_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + CMDQ_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + CMDQ_AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CMDQ_CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CMDQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full command queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("pop from an empty command queue");

endmodule

// ===== rtl/ucs_back.sv =====
// ----------------------------------------------------------------------------
// ucs_back
// Executes queued commands: owns the scheme hold buffer and sends one
// result transfer per cycle through the output register while it is free.
// ----------------------------------------------------------------------------
module ucs_back import ucs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  hold_wr_type hold_wr,
   input  logic        head_valid,
   input  cmd_type     head_cmd,
   output logic        pop,
   output logic        flush_done,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_component,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_of_run
);

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_START = 5'b00010,
      PH_HOLD  = 5'b00100,
      PH_SLASH = 5'b01000,
      PH_TAIL  = 5'b10000
   } phase_type;

   logic [7:0]            hold_ff [HOLD_CAP];
   phase_type             phase_ff, phase_in;
   phase_type             ph_cur, ph_next, ph_after_hold, ph_after_start, ph_entry;
   logic [HOLD_IDX_W-1:0] idx_ff, idx_in;
   logic                  last_hold;
   logic                  out_free, fire;
   logic                  valid_ff, valid_in;
   logic [1:0]            kind_ff, kind_in;
   logic [2:0]            comp_ff, comp_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   assign out_free  = !valid_ff || rsp_ready;
   assign fire      = out_free && head_valid;
   assign last_hold = (HOLD_CNT_W'(idx_ff) + HOLD_CNT_W'(1)) == head_cmd.flush_cnt;

   always_comb begin
      ph_after_hold  = head_cmd.slash_en ? PH_SLASH :
                       (head_cmd.tail.en ? PH_TAIL : PH_IDLE);
      ph_after_start = (head_cmd.flush_cnt != '0) ? PH_HOLD : ph_after_hold;
      ph_entry       = head_cmd.start_en ? PH_START : ph_after_start;
      ph_cur         = (phase_ff == PH_IDLE) ? ph_entry : phase_ff;
      ph_next        = PH_IDLE;
      kind_in        = KIND_DATA;
      comp_in        = head_cmd.start_comp;
      char_in        = 8'h00;
      unique case (ph_cur)
         PH_START: begin
            kind_in = KIND_START;
            ph_next = ph_after_start;
         end
         PH_HOLD: begin
            char_in = hold_ff[idx_ff];
            ph_next = last_hold ? ph_after_hold : PH_HOLD;
         end
         PH_SLASH: begin
            comp_in = COMP_PATH;
            char_in = CH_SLASH;
            ph_next = head_cmd.tail.en ? PH_TAIL : PH_IDLE;
         end
         PH_TAIL: begin
            kind_in = head_cmd.tail.kind;
            comp_in = head_cmd.tail.comp;
            char_in = head_cmd.tail.chr;
         end
         default: begin
            ph_next = PH_IDLE;
         end
      endcase
      last_in  = ph_next == PH_IDLE;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (fire) begin
         phase_in = ph_next;
         idx_in   = (ph_cur == PH_HOLD && ph_next == PH_HOLD) ?
                    idx_ff + HOLD_IDX_W'(1) : '0;
      end
      valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   assign pop        = fire && ph_next == PH_IDLE;
   assign flush_done = pop && head_cmd.flush_cnt != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff <= kind_in;
         comp_ff <= comp_in;
         char_ff <= char_in;
         last_ff <= last_in;
      end
      if (hold_wr.en) begin
         hold_ff[hold_wr.addr] <= hold_wr.data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_component   = comp_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_last_of_run = last_ff;

   a_phase_has_cmd: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> head_valid)
      else $error("command phase active with no queued command");

   a_no_write_during_flush: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HOLD |-> !hold_wr.en)
      else $error("hold buffer written while it is being flushed");

endmodule

// ===== rtl/uri_component_splitter_top.sv =====
// ----------------------------------------------------------------------------
// uri_component_splitter_top
// Splits a byte stream URI into scheme, authority, path, query and fragment
// start markers and data transfers, with a done marker at the end of a URI.
// ----------------------------------------------------------------------------
// Channel   Ports                               Direction
// req       req_valid/ready, char_code, is_end  in
// rsp       rsp_valid/ready, kind, component,   out
//           out_char, last_of_run
//
// An item giving n results occupies the back end until all n have gone out,
// so a plain data byte moves at one per cycle while the output is not stalled.
// A command that flushes the scheme hold buffer stops input acceptance from
// its own transfer until the cycle after the back end has loaded its last
// result; the held bytes go out one per cycle while the output is not stalled.
// Synchronous active-high reset returns the parser to the start of a URI.
// The two-entry command queue lets input and output stall independently.
// ----------------------------------------------------------------------------
module uri_component_splitter_top import ucs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_is_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_component,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   logic        q_full, q_push, q_pop, q_head_valid, flush_done;
   cmd_type     q_cmd, q_head;
   hold_wr_type hold_wr;

   ucs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_end    (req_is_end),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_cmd),
      .hold_wr       (hold_wr),
      .flush_done    (flush_done)
   );

   ucs_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head)
   );

   ucs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .hold_wr         (hold_wr),
      .head_valid      (q_head_valid),
      .head_cmd        (q_head),
      .pop             (q_pop),
      .flush_done      (flush_done),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_component   (rsp_component),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
